// ----- hdl/rgbo_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbo_pkg: shared types and constants for the RGBA over compositor
// Pixel layout, blend selection codes and the item record passed down the
// divider pipeline.
// ----------------------------------------------------------------------------
package rgbo_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned WGT_W          = 16;
  localparam int unsigned DIV_W          = 24;
  localparam int unsigned CHANNELS       = 3;
  localparam int unsigned DIV_STAGES     = 4;
  localparam int unsigned BITS_PER_STAGE = PIX_W / DIV_STAGES;
  localparam logic [PIX_W-1:0] CH_MAX    = 8'd255;
  localparam logic [PIX_W-1:0] CH_ZERO   = 8'd0;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pixel_t;

  typedef enum logic [1:0] {
    SEL_BLEND = 2'd0,
    SEL_BASE  = 2'd1,
    SEL_OVER  = 2'd2
  } sel_t;

  typedef struct packed {
    sel_t                              sel;
    pixel_t                            pass_pix;
    logic [PIX_W-1:0]                  alpha_q;
    logic [DIV_W-1:0]                  dshift;
    logic [CHANNELS-1:0][DIV_W-1:0]    rem;
    logic [CHANNELS-1:0][PIX_W-1:0]    quo;
  } div_item_t;

endpackage

// ----- hdl/rgbo_if.sv -----
// ----------------------------------------------------------------------------
// rgbo_if: stream interfaces of the RGBA over compositor
// Input channel carries a base and overlay pixel pair, output channel the
// composited pixel. Valid/ready handshake on both.
// ----------------------------------------------------------------------------
interface rgbo_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic [7:0] base_alpha;
  logic [7:0] over_red;
  logic [7:0] over_green;
  logic [7:0] over_blue;
  logic [7:0] over_alpha;

  modport source (
    output valid, base_red, base_green, base_blue, base_alpha,
           over_red, over_green, over_blue, over_alpha,
    input  ready
  );
  modport sink (
    input  valid, base_red, base_green, base_blue, base_alpha,
           over_red, over_green, over_blue, over_alpha,
    output ready
  );
endinterface

interface rgbo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

// ----- hdl/rgbo_front.sv -----
// ----------------------------------------------------------------------------
// rgbo_front: weight and numerator stages
// Stage A forms the two alpha weights and classifies the pair; stage B forms
// the combined weight, the rounded output alpha and the three numerators.
// ----------------------------------------------------------------------------
module rgbo_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgbo_pkg::pixel_t   base_pix,
  input  rgbo_pkg::pixel_t   over_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbo_pkg::div_item_t out_item
);
  import rgbo_pkg::*;

  // stage A registers
  logic                           valid_a_r;
  sel_t                           sel_a_r, sel_a_nxt;
  pixel_t                         pass_a_r, pass_a_nxt;
  logic [WGT_W-1:0]               ow_a_r, ow_a_nxt;
  logic [WGT_W-1:0]               bw_a_r, bw_a_nxt;
  logic [CHANNELS-1:0][PIX_W-1:0] base_c_a_r, over_c_a_r;
  logic                           ready_a;

  // stage B registers
  logic                           valid_b_r;
  div_item_t                      item_b_r, item_b_nxt;

  logic [PIX_W-1:0]               inv_a;
  logic [WGT_W:0]                 wsum;
  logic [WGT_W-1:0]               weight;
  logic [DIV_W:0]                 asum;
  logic [DIV_W:0]                 num [CHANNELS];

  // -------- stage A --------
  assign ready_a  = !valid_b_r || out_ready;
  assign in_ready = !valid_a_r || ready_a;

  always_comb begin
    inv_a    = CH_MAX - over_pix.alpha;
    ow_a_nxt = {over_pix.alpha, 8'd0} - {8'd0, over_pix.alpha};
    bw_a_nxt = base_pix.alpha * inv_a;
    if (over_pix.alpha == CH_ZERO) begin
      sel_a_nxt  = SEL_BASE;
      pass_a_nxt = base_pix;
    end else if (base_pix.alpha == CH_ZERO || over_pix.alpha == CH_MAX) begin
      sel_a_nxt  = SEL_OVER;
      pass_a_nxt = over_pix;
    end else begin
      sel_a_nxt  = SEL_BLEND;
      pass_a_nxt = over_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (in_ready) begin
      valid_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sel_a_r    <= sel_a_nxt;
      pass_a_r   <= pass_a_nxt;
      ow_a_r     <= ow_a_nxt;
      bw_a_r     <= bw_a_nxt;
      base_c_a_r <= {base_pix.red, base_pix.green, base_pix.blue};
      over_c_a_r <= {over_pix.red, over_pix.green, over_pix.blue};
    end
  end

  // -------- stage B --------
  always_comb begin
    wsum   = {1'b0, ow_a_r} + {1'b0, bw_a_r};
    weight = wsum[WGT_W-1:0];
    // alpha = (weight * 257 + 256) >> 16
    asum   = {1'b0, weight, 8'd0} + {9'd0, weight} + (DIV_W+1)'(256);
    item_b_nxt.sel      = sel_a_r;
    item_b_nxt.pass_pix = pass_a_r;
    item_b_nxt.alpha_q  = asum[DIV_W-1:WGT_W];
    item_b_nxt.dshift   = {1'b0, weight, 7'd0};
    for (int c = 0; c < CHANNELS; c++) begin
      num[c] = (DIV_W+1)'(over_c_a_r[c]) * (DIV_W+1)'(ow_a_r)
             + (DIV_W+1)'(base_c_a_r[c]) * (DIV_W+1)'(bw_a_r);
      item_b_nxt.rem[c] = num[c][DIV_W-1:0];
      item_b_nxt.quo[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (ready_a) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a_r && ready_a) begin
      item_b_r <= item_b_nxt;
    end
  end

  assign out_valid = valid_b_r;
  assign out_item  = item_b_r;

endmodule

// ----- hdl/rgbo_div_stage.sv -----
// ----------------------------------------------------------------------------
// rgbo_div_stage: one stage of the restoring divider
// Retires a few quotient bits on all three color channels and shifts the
// divisor down for the next stage.
// ----------------------------------------------------------------------------
module rgbo_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgbo_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rgbo_pkg::div_item_t out_item
);
  import rgbo_pkg::*;

  logic             valid_r;
  div_item_t        item_r, item_nxt;
  logic [DIV_W-1:0] d;
  logic [DIV_W-1:0] r;
  logic [PIX_W-1:0] q;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    item_nxt = in_item;
    for (int c = 0; c < CHANNELS; c++) begin
      d = in_item.dshift;
      r = in_item.rem[c];
      q = in_item.quo[c];
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
        if (r >= d) begin
          r = r - d;
          q = {q[PIX_W-2:0], 1'b1};
        end else begin
          q = {q[PIX_W-2:0], 1'b0};
        end
        d = d >> 1;
      end
      item_nxt.rem[c] = r;
      item_nxt.quo[c] = q;
    end
    item_nxt.dshift = in_item.dshift >> BITS_PER_STAGE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- hdl/rgba_over_compositor.sv -----
// ----------------------------------------------------------------------------
// rgba_over_compositor: Porter-Duff over on straight-alpha RGBA8888 pixels
// Pipelined compositor: weight stages followed by a staged divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_px  carries one base/overlay pixel pair per item, out_px one
//   composited pixel per item; both use a valid/ready handshake.
//   A transparent overlay passes the base; a transparent base or opaque
//   overlay passes the overlay; otherwise each color is the weighted sum
//   divided by the combined weight, and alpha is that weight over 255.
//   Each item passes two weight/numerator stages, then four divider stages
//   of two quotient bits each, the last doubling as the output register.
//   Throughput: one item per cycle while out_px is ready; every stage holds
//   its own valid bit.
//   Reset (synchronous, rst_n low) empties the pipeline; there is no other
//   state. When out_px stalls, each full stage holds while empty stages
//   upstream keep filling, so in_px.ready drops only once all six are full.
// ----------------------------------------------------------------------------
module rgba_over_compositor (
  input  logic       clk,
  input  logic       rst_n,
  rgbo_in_if.sink    in_px,
  rgbo_out_if.source out_px
);
  import rgbo_pkg::*;

  pixel_t    base_pix, over_pix;
  logic      valid_s [DIV_STAGES+1];
  logic      ready_s [DIV_STAGES+1];
  div_item_t item_s  [DIV_STAGES+1];
  div_item_t fin;

  assign base_pix = '{red: in_px.base_red, green: in_px.base_green,
                      blue: in_px.base_blue, alpha: in_px.base_alpha};
  assign over_pix = '{red: in_px.over_red, green: in_px.over_green,
                      blue: in_px.over_blue, alpha: in_px.over_alpha};

  rgbo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .base_pix  (base_pix),
    .over_pix  (over_pix),
    .out_valid (valid_s[0]),
    .out_ready (ready_s[0]),
    .out_item  (item_s[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rgbo_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_s[g]),
      .in_ready  (ready_s[g]),
      .in_item   (item_s[g]),
      .out_valid (valid_s[g+1]),
      .out_ready (ready_s[g+1]),
      .out_item  (item_s[g+1])
    );
  end

  assign fin                 = item_s[DIV_STAGES];
  assign out_px.valid        = valid_s[DIV_STAGES];
  assign ready_s[DIV_STAGES] = out_px.ready;

  // pick passthrough pixel or blended result
  always_comb begin
    unique case (fin.sel)
      SEL_BASE, SEL_OVER: begin
        out_px.out_red   = fin.pass_pix.red;
        out_px.out_green = fin.pass_pix.green;
        out_px.out_blue  = fin.pass_pix.blue;
        out_px.out_alpha = fin.pass_pix.alpha;
      end
      SEL_BLEND: begin
        out_px.out_red   = fin.quo[2];
        out_px.out_green = fin.quo[1];
        out_px.out_blue  = fin.quo[0];
        out_px.out_alpha = fin.alpha_q;
      end
      default: begin
        out_px.out_red   = fin.quo[2];
        out_px.out_green = fin.quo[1];
        out_px.out_blue  = fin.quo[0];
        out_px.out_alpha = fin.alpha_q;
      end
    endcase
  end

endmodule
